[src/m68kea_pkg.sv]
// ----------------------------------------------------------------------------
// m68kea_pkg
// Types, codes and helpers shared by the effective address unit.
// ----------------------------------------------------------------------------
package m68kea_pkg;

	localparam int unsigned DATA_W   = 32;
	localparam int unsigned RF_DEPTH = 16;
	localparam int unsigned RF_AW    = $clog2(RF_DEPTH);

	// Address registers sit in the upper half of the file
	localparam logic AREG_SEL = 1'b1;

	// Brief extension word: long index select
	localparam int unsigned IDX_LONG_BIT = 11;

	localparam logic REQ_COMPUTE = 1'b0;
	localparam logic REQ_WRITE   = 1'b1;

	localparam logic [2:0] MODE_AREG_IND = 3'd2;
	localparam logic [2:0] MODE_AREG_D16 = 3'd5;
	localparam logic [2:0] MODE_AREG_IDX = 3'd6;
	localparam logic [2:0] MODE_EXT      = 3'd7;

	localparam logic [2:0] EXT_ABS_W  = 3'd0;
	localparam logic [2:0] EXT_ABS_L  = 3'd1;
	localparam logic [2:0] EXT_PC_D16 = 3'd2;
	localparam logic [2:0] EXT_PC_IDX = 3'd3;

	typedef struct packed {
		logic [2:0] mode;
		logic [2:0] reg_num;
	} ea_ctl_t;

	function automatic logic [DATA_W-1:0] sext16(input logic [15:0] v);
		return {{(DATA_W-16){v[15]}}, v};
	endfunction

	function automatic logic [DATA_W-1:0] sext8(input logic [7:0] v);
		return {{(DATA_W-8){v[7]}}, v};
	endfunction

endpackage

[src/m68kea_req_if.sv]
// ----------------------------------------------------------------------------
// m68kea_req_if
// Request channel: compute or register write items.
// ----------------------------------------------------------------------------
interface m68kea_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [2:0]  mode;
	logic [2:0]  reg_num;
	logic [31:0] pc;
	logic [15:0] ext_word;
	logic [31:0] ext_long;
	logic [3:0]  write_index;
	logic [31:0] write_value;

	modport source (
		output valid, req_type, mode, reg_num, pc, ext_word, ext_long,
			write_index, write_value,
		input ready
	);

	modport sink (
		input valid, req_type, mode, reg_num, pc, ext_word, ext_long,
			write_index, write_value,
		output ready
	);
endinterface

[src/m68kea_rsp_if.sv]
// ----------------------------------------------------------------------------
// m68kea_rsp_if
// Result channel: effective address, advanced PC and illegal flag.
// ----------------------------------------------------------------------------
interface m68kea_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] address;
	logic [31:0] next_pc;
	logic        illegal;

	modport source (
		output valid, address, next_pc, illegal,
		input ready
	);

	modport sink (
		input valid, address, next_pc, illegal,
		output ready
	);
endinterface

[src/m68kea_regfile.sv]
// ----------------------------------------------------------------------------
// m68kea_regfile
// 16 x 32 register file, one write port and two registered read ports.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module m68kea_regfile (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  logic [m68kea_pkg::RF_AW-1:0]           wr_addr,
	input  logic [m68kea_pkg::DATA_W-1:0]          wr_data,
	input  logic                                   rd_en,
	input  logic [m68kea_pkg::RF_AW-1:0]           rd_addr_a,
	input  logic [m68kea_pkg::RF_AW-1:0]           rd_addr_b,
	output logic [m68kea_pkg::DATA_W-1:0]          rd_data_a,
	output logic [m68kea_pkg::DATA_W-1:0]          rd_data_b
);
	import m68kea_pkg::*;

	logic [DATA_W-1:0]   mem_q [RF_DEPTH];
	logic [RF_DEPTH-1:0] valid_q;
	logic [DATA_W-1:0]   rd_a_q;
	logic [DATA_W-1:0]   rd_b_q;
	logic                rd_a_vld_q;
	logic                rd_b_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem_q[rd_addr_a];
			rd_b_q <= mem_q[rd_addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_a_vld_q <= 1'b0;
			rd_b_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_a_vld_q <= valid_q[rd_addr_a];
				rd_b_vld_q <= valid_q[rd_addr_b];
			end
		end
	end

	assign rd_data_a = rd_a_vld_q ? rd_a_q : '0;
	assign rd_data_b = rd_b_vld_q ? rd_b_q : '0;

endmodule

[src/m68kea_agen.sv]
// ----------------------------------------------------------------------------
// m68kea_agen
// Effective address and PC advance for the supported memory modes.
// ----------------------------------------------------------------------------
module m68kea_agen (
	input  m68kea_pkg::ea_ctl_t                ctl,
	input  logic [m68kea_pkg::DATA_W-1:0]      pc,
	input  logic [15:0]                        ext_word,
	input  logic [m68kea_pkg::DATA_W-1:0]      ext_long,
	input  logic [m68kea_pkg::DATA_W-1:0]      base,
	input  logic [m68kea_pkg::DATA_W-1:0]      index,
	output logic [m68kea_pkg::DATA_W-1:0]      address,
	output logic [m68kea_pkg::DATA_W-1:0]      next_pc,
	output logic                               illegal
);
	import m68kea_pkg::*;

	logic [DATA_W-1:0] idx_val;
	logic [DATA_W-1:0] brief_off;
	logic [DATA_W-1:0] pc_plus2;
	logic [DATA_W-1:0] pc_plus4;

	// word index uses the sign-extended low half of Xn
	assign idx_val   = ext_word[IDX_LONG_BIT] ? index : sext16(index[15:0]);
	assign brief_off = sext8(ext_word[7:0]) + idx_val;
	assign pc_plus2  = pc + DATA_W'(2);
	assign pc_plus4  = pc + DATA_W'(4);

	always_comb begin
		address = '0;
		next_pc = pc;
		illegal = 1'b0;
		case (ctl.mode)
			MODE_AREG_IND: begin
				address = base;
			end
			MODE_AREG_D16: begin
				address = base + sext16(ext_word);
				next_pc = pc_plus2;
			end
			MODE_AREG_IDX: begin
				address = base + brief_off;
				next_pc = pc_plus2;
			end
			MODE_EXT: begin
				case (ctl.reg_num)
					EXT_ABS_W: begin
						address = sext16(ext_word);
						next_pc = pc_plus2;
					end
					EXT_ABS_L: begin
						address = ext_long;
						next_pc = pc_plus4;
					end
					EXT_PC_D16: begin
						address = pc + sext16(ext_word);
						next_pc = pc_plus2;
					end
					EXT_PC_IDX: begin
						address = pc + brief_off;
						next_pc = pc_plus2;
					end
					default: begin
						illegal = 1'b1;
					end
				endcase
			end
			default: begin
				illegal = 1'b1;
			end
		endcase
	end

endmodule

[src/m68k_effective_address_unit_core.sv]
// A compute item passes the register file read registers, then the result
// output register, which stalls while it is full and not taken. Requests are
// taken only in IDLE, one register write per cycle, none during a compute.
// Reset clears all control state at once; per-entry valid bits make the
// register file read as zero until written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// m68k_effective_address_unit_core
// Top level: request FSM, register file reads and result output register.
// ----------------------------------------------------------------------------
module m68k_effective_address_unit_core (
	input  logic         clk,
	input  logic         arst_n,
	m68kea_req_if.sink   req,
	m68kea_rsp_if.source rsp
);
	import m68kea_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_CALC = 2'b10
	} state_t;

	state_t state_q;

	logic req_xfer;
	logic cmp_xfer;
	logic wr_xfer;
	logic out_load;

	ea_ctl_t           ctl_s1;
	logic [DATA_W-1:0] pc_s1;
	logic [15:0]       ext_word_s1;
	logic [DATA_W-1:0] ext_long_s1;

	logic [DATA_W-1:0] base_rd;
	logic [DATA_W-1:0] index_rd;
	logic [DATA_W-1:0] ea_addr;
	logic [DATA_W-1:0] ea_npc;
	logic              ea_illegal;

	logic              out_valid_q;
	logic [DATA_W-1:0] address_q;
	logic [DATA_W-1:0] next_pc_q;
	logic              illegal_q;

	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign cmp_xfer  = req_xfer && (req.req_type == REQ_COMPUTE);
	assign wr_xfer   = req_xfer && (req.req_type == REQ_WRITE);
	assign out_load  = (state_q == ST_CALC) && (!out_valid_q || rsp.ready);

	m68kea_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_xfer),
		.wr_addr   (req.write_index),
		.wr_data   (req.write_value),
		.rd_en     (cmp_xfer),
		.rd_addr_a ({AREG_SEL, req.reg_num}),
		.rd_addr_b (req.ext_word[15:12]),
		.rd_data_a (base_rd),
		.rd_data_b (index_rd)
	);

	m68kea_agen u_agen (
		.ctl      (ctl_s1),
		.pc       (pc_s1),
		.ext_word (ext_word_s1),
		.ext_long (ext_long_s1),
		.base     (base_rd),
		.index    (index_rd),
		.address  (ea_addr),
		.next_pc  (ea_npc),
		.illegal  (ea_illegal)
	);

	always_ff @(posedge clk) begin
		if (cmp_xfer) begin
			ctl_s1.mode    <= req.mode;
			ctl_s1.reg_num <= req.reg_num;
			pc_s1          <= req.pc;
			ext_word_s1    <= req.ext_word;
			ext_long_s1    <= req.ext_long;
		end
		if (out_load) begin
			address_q <= ea_addr;
			next_pc_q <= ea_npc;
			illegal_q <= ea_illegal;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmp_xfer) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					// hold read data until the output register frees up
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.address = address_q;
	assign rsp.next_pc = next_pc_q;
	assign rsp.illegal = illegal_q;

`ifndef SYNTH
	a_cmp_enters_calc: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_xfer |=> (state_q == ST_CALC))
		else $error("compute transfer did not enter CALC");

	a_wr_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_xfer |=> (state_q == ST_IDLE))
		else $error("register write left IDLE");

	a_load_gives_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> rsp.valid)
		else $error("result load did not raise valid");

	a_calc_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) |-> !req.ready)
		else $error("request taken while computing");

	a_calc_stalls_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_CALC) && out_valid_q && !rsp.ready) |=> (state_q == ST_CALC))
		else $error("CALC left while output register full");
`endif

endmodule
